@@ src/mck_pkg.sv @@
// shared types, widths, register indexes and the letter code table for the morse keyer
// no dependencies
package mck_pkg;

    localparam int CHAR_W    = 8;
    localparam int DOT_W     = 10;
    localparam int FREQ_W    = 15;
    localparam int TONE_W    = 12;
    localparam int GAP_W     = 13;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 15;
    localparam int IDX_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_DOT_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQ  = 2'd1;

    localparam logic [DOT_W-1:0]  DOT_RESET  = 10'd60;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 15'd698;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] CASE_MASK    = 8'hdf;

    // dashes: bit i set means symbol i is a dash, symbol 0 sent first
    typedef struct packed {
        logic             coded;
        logic [CNT_W-1:0] len;
        logic [3:0]       dashes;
    } code_t;

    function automatic code_t letter_code(input logic [IDX_W-1:0] idx);
        code_t c;
        c.coded = 1'b1;
        case (idx)
            5'd0:    begin c.len = 3'd2; c.dashes = 4'b0010; end
            5'd1:    begin c.len = 3'd4; c.dashes = 4'b0001; end
            5'd2:    begin c.len = 3'd4; c.dashes = 4'b0101; end
            5'd3:    begin c.len = 3'd3; c.dashes = 4'b0001; end
            5'd4:    begin c.len = 3'd1; c.dashes = 4'b0000; end
            5'd5:    begin c.len = 3'd4; c.dashes = 4'b0100; end
            5'd6:    begin c.len = 3'd3; c.dashes = 4'b0011; end
            5'd7:    begin c.len = 3'd4; c.dashes = 4'b0000; end
            5'd8:    begin c.len = 3'd2; c.dashes = 4'b0000; end
            5'd9:    begin c.len = 3'd4; c.dashes = 4'b1110; end
            5'd10:   begin c.len = 3'd3; c.dashes = 4'b0101; end
            5'd11:   begin c.len = 3'd4; c.dashes = 4'b0010; end
            5'd12:   begin c.len = 3'd2; c.dashes = 4'b0011; end
            5'd13:   begin c.len = 3'd2; c.dashes = 4'b0001; end
            5'd14:   begin c.len = 3'd3; c.dashes = 4'b0111; end
            5'd15:   begin c.len = 3'd4; c.dashes = 4'b0110; end
            5'd16:   begin c.len = 3'd4; c.dashes = 4'b1011; end
            5'd17:   begin c.len = 3'd3; c.dashes = 4'b0010; end
            5'd18:   begin c.len = 3'd3; c.dashes = 4'b0000; end
            5'd19:   begin c.len = 3'd1; c.dashes = 4'b0001; end
            5'd20:   begin c.len = 3'd3; c.dashes = 4'b0100; end
            5'd21:   begin c.len = 3'd4; c.dashes = 4'b1000; end
            5'd22:   begin c.len = 3'd3; c.dashes = 4'b0110; end
            5'd23:   begin c.len = 3'd4; c.dashes = 4'b1001; end
            5'd24:   begin c.len = 3'd4; c.dashes = 4'b1101; end
            5'd25:   begin c.len = 3'd4; c.dashes = 4'b0011; end
            default: begin c.coded = 1'b0; c.len = 3'd1; c.dashes = 4'b0000; end
        endcase
        return c;
    endfunction

endpackage

@@ src/mck_decoder.sv @@
// character decoder: maps an ascii byte to its morse symbol count and dash pattern
// depends on mck_pkg
module mck_decoder (
    input  logic [mck_pkg::CHAR_W-1:0] character,
    output mck_pkg::code_t             code
);
    import mck_pkg::*;

    logic              is_upper;
    logic              is_lower;
    logic [CHAR_W-1:0] folded;
    logic [CHAR_W-1:0] offset;

    always_comb
    begin
        is_upper = (character >= CHAR_UPPER_A) && (character <= CHAR_UPPER_Z);
        is_lower = (character >= CHAR_LOWER_A) && (character <= CHAR_LOWER_Z);
        folded   = character & CASE_MASK;
        offset   = folded - CHAR_UPPER_A;
        if (is_upper || is_lower)
        begin
            code = letter_code(offset[IDX_W-1:0]);
        end
        else
        begin
            // silent symbol with word gap
            code.coded  = 1'b0;
            code.len    = 3'd1;
            code.dashes = 4'b0000;
        end
    end

endmodule

@@ src/mck_emitter.sv @@
// symbol sequencer: holds the current character code and shifts out one symbol
// per cycle into the result register while the output is not stalled; depends on mck_pkg
module mck_emitter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  mck_pkg::code_t              code,
    input  logic [mck_pkg::DOT_W-1:0]   dot_len,
    input  logic [mck_pkg::FREQ_W-1:0]  freq,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mck_pkg::TONE_W-1:0]  tone_ms,
    output logic [mck_pkg::GAP_W-1:0]   gap_ms,
    output logic [mck_pkg::FREQ_W-1:0]  frequency_hz,
    output logic                        last_symbol
);
    import mck_pkg::*;

    logic              item_valid_reg, item_valid_next;
    logic              coded_reg, coded_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [3:0]        dashes_reg, dashes_next;

    logic              out_valid_reg, out_valid_next;
    logic [TONE_W-1:0] tone_reg, tone_next;
    logic [GAP_W-1:0]  gap_reg, gap_next;
    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic              last_reg, last_next;

    logic              slot_free;
    logic              emit;
    logic              is_last;
    logic              accept;
    logic [TONE_W-1:0] dot1;
    logic [TONE_W-1:0] dot3;
    logic [GAP_W-1:0]  dot7;

    always_comb
    begin
        slot_free = !out_valid_reg || !out_stall;
        emit      = item_valid_reg && slot_free;
        is_last   = (count_reg == 3'd1);
        in_stall  = item_valid_reg && !(emit && is_last);
        accept    = in_valid && !in_stall;

        dot1 = {2'b00, dot_len};
        dot3 = {1'b0, dot_len, 1'b0} + {2'b00, dot_len};
        dot7 = {dot_len, 3'b000} - {3'b000, dot_len};

        item_valid_next = item_valid_reg;
        coded_next      = coded_reg;
        count_next      = count_reg;
        dashes_next     = dashes_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
            coded_next      = code.coded;
            count_next      = code.len;
            dashes_next     = code.dashes;
        end
        else if (emit)
        begin
            item_valid_next = !is_last;
            count_next      = count_reg - 3'd1;
            dashes_next     = {1'b0, dashes_reg[3:1]};
        end

        out_valid_next = out_valid_reg;
        tone_next      = tone_reg;
        gap_next       = gap_reg;
        freq_next      = freq_reg;
        last_next      = last_reg;
        if (slot_free)
        begin
            out_valid_next = item_valid_reg;
        end
        if (emit)
        begin
            freq_next = freq;
            last_next = is_last;
            if (!coded_reg)
            begin
                tone_next = '0;
                gap_next  = dot7;
            end
            else
            begin
                tone_next = dashes_reg[0] ? dot3 : dot1;
                gap_next  = is_last ? {1'b0, dot3} : {1'b0, dot1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coded_reg  <= coded_next;
        count_reg  <= count_next;
        dashes_reg <= dashes_next;
        tone_reg   <= tone_next;
        gap_reg    <= gap_next;
        freq_reg   <= freq_next;
        last_reg   <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign tone_ms      = tone_reg;
    assign gap_ms       = gap_reg;
    assign frequency_hz = freq_reg;
    assign last_symbol  = last_reg;

endmodule

@@ src/morse_code_keyer.sv @@
// top level of the morse keyer: configuration registers, decoder and symbol sequencer
// depends on mck_pkg, mck_decoder and mck_emitter
//
// A character is decoded as it is accepted and then gives one symbol request
// per cycle into the result register while the output is not stalled: a letter
// of n symbols (1 to 4) gives n requests, any other byte one. The next character
// is accepted in the same cycle that the last symbol of the current one moves
// into the result register. The accepted code is held in the item registers,
// and each of its symbols moves from there into the result register. Dot length and
// frequency are sampled as each symbol is produced; write them only while idle.
module morse_code_keyer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [mck_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mck_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mck_pkg::CHAR_W-1:0]     character,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mck_pkg::TONE_W-1:0]     tone_ms,
    output logic [mck_pkg::GAP_W-1:0]      gap_ms,
    output logic [mck_pkg::FREQ_W-1:0]     frequency_hz,
    output logic                           last_symbol
);
    import mck_pkg::*;

    logic [DOT_W-1:0]  dot_reg, dot_next;
    logic [FREQ_W-1:0] freq_reg, freq_next;
    code_t             code;

    always_comb
    begin
        dot_next  = dot_reg;
        freq_next = freq_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_DOT_LENGTH: dot_next  = cfg_data[DOT_W-1:0];
                REG_TONE_FREQ:  freq_next = cfg_data[FREQ_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= DOT_RESET;
            freq_reg <= FREQ_RESET;
        end
        else
        begin
            dot_reg  <= dot_next;
            freq_reg <= freq_next;
        end
    end

    mck_decoder u_decoder (
        .character (character),
        .code      (code)
    );

    mck_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code         (code),
        .dot_len      (dot_reg),
        .freq         (freq_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tone_ms      (tone_ms),
        .gap_ms       (gap_ms),
        .frequency_hz (frequency_hz),
        .last_symbol  (last_symbol)
    );

endmodule

@@ src/mck_checker.sv @@
// port-level checks for the morse keyer, bound to the top level
// depends on mck_pkg and morse_code_keyer
module mck_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [mck_pkg::TONE_W-1:0]    tone_ms,
    input logic [mck_pkg::GAP_W-1:0]     gap_ms,
    input logic                          last_symbol
);
    import mck_pkg::*;

    logic [GAP_W:0] tone_x1;
    logic [GAP_W:0] tone_x3;
    logic [GAP_W:0] gap_x1;
    logic [GAP_W:0] gap_x3;

    assign tone_x1 = {2'b00, tone_ms};
    assign tone_x3 = {2'b00, tone_ms} + {1'b0, tone_ms, 1'b0};
    assign gap_x1  = {1'b0, gap_ms};
    assign gap_x3  = {1'b0, gap_ms} + {gap_ms, 1'b0};

    // a stalled request keeps its tone, gap and last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tone_ms) && $stable(gap_ms)
            && $stable(last_symbol))
        else $error("stalled result request changed");

    // inside a letter the gap is one dot and the tone one or three dots
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_symbol |-> (tone_x1 == gap_x1) || (tone_x1 == gap_x3))
        else $error("inner symbol tone and gap out of ratio");

    // a sounded final symbol is followed by a three-dot letter gap
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_symbol && (tone_ms != '0) |-> (gap_x1 == tone_x3) || (gap_x1 == tone_x1))
        else $error("final symbol gap is not a letter gap");

endmodule

bind morse_code_keyer mck_checker u_mck_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tone_ms     (tone_ms),
    .gap_ms      (gap_ms),
    .last_symbol (last_symbol)
);

@@ sim/morse_code_keyer_tb.sv @@
// self-checking testbench for morse_code_keyer: directed and random characters over several
// dot length and frequency settings, random idling on both sides and one long output hold-off
// depends on mck_pkg and morse_code_keyer
module morse_code_keyer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mck_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PERCENT = 36;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;

    localparam int DASH_UNITS       = 3;
    localparam int LETTER_GAP_UNITS = 3;
    localparam int WORD_GAP_UNITS   = 7;

    localparam logic [CHAR_W-1:0] LOWER_A = "a";
    localparam logic [CHAR_W-1:0] LOWER_Z = "z";
    localparam logic [CHAR_W-1:0] UPPER_A = "A";
    localparam logic [CHAR_W-1:0] UPPER_Z = "Z";

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [TONE_W-1:0] tone;
        logic [GAP_W-1:0]  gap;
        logic [FREQ_W-1:0] freq;
        logic              last;
    } symbol_t;

    class keyer_scoreboard;
        symbol_t           expected_symbols[$];
        string             patterns[26];
        logic [DOT_W-1:0]  dot_len;
        logic [FREQ_W-1:0] freq;
        int                errors;
        int                checked;
        int                chars;

        function new();
            patterns = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                         ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                         "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
            dot_len = DOT_RESET;
            freq    = FREQ_RESET;
            errors  = 0;
            checked = 0;
            chars   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_DOT_LENGTH: dot_len = data[DOT_W-1:0];
                REG_TONE_FREQ:  freq    = data[FREQ_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_char(logic [CHAR_W-1:0] ch);
            int      letter;
            int      dot;
            string   pattern;
            symbol_t s;
            chars++;
            dot    = int'(dot_len);
            letter = -1;
            if (ch >= LOWER_A && ch <= LOWER_Z)
                letter = int'(ch - LOWER_A);
            else if (ch >= UPPER_A && ch <= UPPER_Z)
                letter = int'(ch - UPPER_A);
            s.freq = freq;
            if (letter < 0)
            begin
                s.tone = '0;
                s.gap  = GAP_W'(WORD_GAP_UNITS * dot);
                s.last = 1'b1;
                expected_symbols.push_back(s);
                return;
            end
            pattern = patterns[letter];
            for (int i = 0; i < pattern.len(); i++)
            begin
                s.tone = TONE_W'((pattern[i] == "-" ? DASH_UNITS : 1) * dot);
                s.last = (i == pattern.len() - 1);
                s.gap  = GAP_W'((s.last ? LETTER_GAP_UNITS : 1) * dot);
                expected_symbols.push_back(s);
            end
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR at %0t: %s", $realtime, msg);
        endfunction

        function void check_symbol(logic [TONE_W-1:0] tone, logic [GAP_W-1:0] gap,
                                   logic [FREQ_W-1:0] f, logic last);
            symbol_t want;
            checked++;
            if (expected_symbols.size() == 0)
            begin
                flag($sformatf("unexpected symbol tone %0d gap %0d freq %0d last %0d",
                               tone, gap, f, last));
                return;
            end
            want = expected_symbols.pop_front();
            if (tone !== want.tone || gap !== want.gap || f !== want.freq || last !== want.last)
                flag($sformatf({"symbol %0d: expected tone %0d gap %0d freq %0d last %0d, ",
                                "got tone %0d gap %0d freq %0d last %0d"}, checked,
                               want.tone, want.gap, want.freq, want.last, tone, gap, f, last));
        endfunction

        function int pending();
            return expected_symbols.size();
        endfunction

        function void report_leftover();
            if (expected_symbols.size() != 0)
                flag($sformatf("%0d expected symbols never arrived", expected_symbols.size()));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_DOT_LENGTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CHAR_W-1:0]    character = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [TONE_W-1:0]    tone_ms;
    logic [GAP_W-1:0]     gap_ms;
    logic [FREQ_W-1:0]    frequency_hz;
    logic                 last_symbol;

    logic no_idle = 1'b0;
    logic start_hold = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   cycle_count = 0;
    int   settings_count = 1;

    logic [CHAR_W-1:0] directed_chars [22] = '{8'h00, 8'hff, "A", "Z", "a", "z", 8'h40,
        8'h5b, 8'h60, 8'h7b, " ", "0", "9", "E", "T", "J", "Q", "Y", "H", 8'h80, 8'hc1, 8'he1};

    keyer_scoreboard sb = new();

    morse_code_keyer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .character    (character),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tone_ms      (tone_ms),
        .gap_ms       (gap_ms),
        .frequency_hz (frequency_hz),
        .last_symbol  (last_symbol)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("morse_code_keyer_tb failed");
            $finish;
        end
    end

    // result side: check accepted symbols, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_symbol(tone_ms, gap_ms, frequency_hz, last_symbol);
            if (start_hold && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return CHAR_W'(UPPER_A + $urandom_range(0, 25));
        else if (r < 70)
            return CHAR_W'(LOWER_A + $urandom_range(0, 25));
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] ch);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        character <= ch;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_char(ch);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(input logic [CFG_W-1:0] dot_data, input logic [CFG_W-1:0] freq_data);
        write_reg(REG_DOT_LENGTH, dot_data);
        write_reg(REG_TONE_FREQ, freq_data);
        cfg_write <= 1'b0;
        settings_count++;
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_char(pick_char());
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values first, with the boundary characters
        foreach (directed_chars[i])
            send_char(directed_chars[i]);
        drain();

        configure(15'd1, 15'd1);
        send_random(60);

        // upper bits of the dot write are dropped, so this gives the longest dot
        configure(15'h7fff, 15'h7fff);
        start_hold <= 1'b1;
        send_random(60);

        configure(15'd0, 15'd0);
        send_random(50);

        configure(15'd1000, 15'd20000);
        no_idle <= 1'b1;
        send_random(60);
        no_idle <= 1'b0;

        write_reg(REG_SPARE_2, CFG_W'($urandom_range(0, 32767)));
        write_reg(REG_SPARE_3, CFG_W'($urandom_range(0, 32767)));
        configure(CFG_W'({$urandom_range(0, 31), 10'($urandom_range(1, 1000))}),
                  CFG_W'($urandom_range(1, 20000)));
        send_random(70);

        configure(CFG_W'($urandom_range(0, 32767)), CFG_W'($urandom_range(0, 32767)));
        send_random(80);

        repeat (TAIL_CYCLES) @(posedge clk);
        sb.report_leftover();

        $display("sent %0d characters under %0d register settings, checked %0d symbols",
                 sb.chars, settings_count, sb.checked);
        $display({"covered all letters in both cases, uncoded bytes, dot lengths 0 to 1023 ",
                  "and a %0d-cycle output hold-off"}, HOLD_CYCLES);
        if (sb.errors == 0)
            $display("morse_code_keyer_tb passed");
        else
        begin
            $display("%0d mismatches", sb.errors);
            $display("morse_code_keyer_tb failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/mck_pkg.sv
src/mck_decoder.sv
src/mck_emitter.sv
src/morse_code_keyer.sv
src/mck_checker.sv
sim/morse_code_keyer_tb.sv
